// ----- hw/rtl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg - shared types and constants for the sine series block
// Field widths, fixed-point constants and the control structs passed between
// the sequencer and the top level.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int ANGLE_W     = 16;
   localparam int SUM_W       = 32;
   localparam int CNT_W       = 4;
   localparam int MAG_W       = 15;
   localparam int XM_W        = 30;
   localparam int OPA_W       = 34;
   localparam int OPB_W       = 32;
   localparam int PROD_W      = OPA_W + OPB_W;
   localparam int FRAC_BITS   = 28;
   localparam int RECIP_SHIFT = 34;
   localparam int NUM_W       = 48;
   localparam int DIV_W       = 18;
   localparam int DEG_SHIFT   = 14;

   localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT      = 16'sd23040;
   localparam logic [CNT_W-1:0]          TERM_COUNT_RESET = 4'd5;

   // degrees (1/128) to Q3.28 radians: am * 314159 * 2^14 / 140625
   localparam logic [OPB_W-1:0] DEG_SCALE = 32'd314159;
   localparam logic [DIV_W-1:0] DEG_DIV   = 18'd140625;
   localparam logic [OPB_W-1:0] DEG_RECIP =
      OPB_W'((66'd1 << (RECIP_SHIFT + DEG_SHIFT)) / 66'd140625);

   typedef struct packed {
      logic start;
      logic out_free;
   } sts_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sts_stat_type;

endpackage

// ----- hw/rtl/sts_mul.sv -----
// ----------------------------------------------------------------------------
// sts_mul - shared registered multiplier
// Unsigned 34 x 32 product, registered; every step of the series runs here.
// ----------------------------------------------------------------------------
module sts_mul (
   input  logic                         clock,
   input  logic [sts_pkg::OPA_W-1:0]    mul_a,
   input  logic [sts_pkg::OPB_W-1:0]    mul_b,
   output logic [sts_pkg::PROD_W-1:0]   prod
);
   import sts_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- hw/rtl/sts_core.sv -----
// ----------------------------------------------------------------------------
// sts_core - series sequencer
// Steps the shared multiplier through angle scaling and each Taylor term.
// Division by a constant is a reciprocal multiply plus one correction step.
// ----------------------------------------------------------------------------
module sts_core #(
   parameter int MAX_TERMS = 15
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  sts_pkg::sts_ctrl_type                 ctl,
   input  logic [sts_pkg::MAG_W-1:0]             angle_mag,
   input  logic                                  angle_neg,
   input  logic [$clog2(MAX_TERMS+1)-1:0]        n_terms,
   output sts_pkg::sts_stat_type                 stat,
   output logic signed [sts_pkg::SUM_W-1:0]      sum,
   output logic [sts_pkg::OPA_W-1:0]             mul_a,
   output logic [sts_pkg::OPB_W-1:0]             mul_b,
   input  logic [sts_pkg::PROD_W-1:0]            prod
);
   import sts_pkg::*;

   localparam int IW = $clog2(MAX_TERMS+1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCALE = 3'd1;
   localparam logic [2:0] ST_RECIP = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_FIX   = 3'd4;
   localparam logic [2:0] ST_MUL1  = 3'd5;
   localparam logic [2:0] ST_MUL2  = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   localparam logic signed [SUM_W+1:0] SUM_MAX = 34'sd2147483647;
   localparam logic signed [SUM_W+1:0] SUM_MIN = -34'sd2147483648;

   // per-term divisor (2i)(2i+1) and floor(2^34 / divisor)
   logic [DIV_W-1:0] div_tab   [1:MAX_TERMS];
   logic [OPB_W-1:0] recip_tab [1:MAX_TERMS];

   for (genvar g = 1; g <= MAX_TERMS; g++) begin : g_tab
      localparam longint unsigned DV = 64'(2 * g) * 64'(2 * g + 1);
      localparam longint unsigned RV = (64'd1 << RECIP_SHIFT) / DV;
      assign div_tab[g]   = DIV_W'(DV);
      assign recip_tab[g] = OPB_W'(RV);
   end

   logic [2:0]           state_ff, state_in;
   logic                 conv_ff, conv_in;
   logic [IW-1:0]        i_ff, i_in;
   logic [IW-1:0]        n_ff, n_in;
   logic                 acc_en_ff, acc_en_in;
   logic [MAG_W-1:0]     am_ff, am_in;
   logic                 neg_ff, neg_in;
   logic [NUM_W-1:0]     num_ff, num_in;
   logic [OPB_W-1:0]     q0_ff, q0_in;
   logic [XM_W-1:0]      xm_ff, xm_in;
   logic [SUM_W-1:0]     tm_ff, tm_in;
   logic                 tneg_ff, tneg_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;

   logic [DIV_W-1:0]     div_sel;
   logic [OPB_W-1:0]     recip_sel;
   logic [NUM_W-1:0]     rem;
   logic                 inc;
   logic [OPB_W:0]       q_fix;
   logic signed [SUM_W+1:0] term_s;
   logic signed [SUM_W+1:0] sum_tot;
   logic signed [SUM_W-1:0] sum_acc;
   logic signed [SUM_W-1:0] x_s;

   assign div_sel   = conv_ff ? DEG_DIV   : div_tab[i_ff];
   assign recip_sel = conv_ff ? DEG_RECIP : recip_tab[i_ff];

   // quotient estimate is low by at most one
   assign rem   = num_ff - prod[NUM_W-1:0];
   assign inc   = (rem >= NUM_W'(div_sel));
   assign q_fix = {1'b0, q0_ff} + (OPB_W+1)'(inc);

   assign x_s = neg_ff ? -$signed({2'b00, q_fix[XM_W-1:0]})
                       :  $signed({2'b00, q_fix[XM_W-1:0]});

   assign term_s  = tneg_ff ? -$signed({2'b00, tm_ff}) : $signed({2'b00, tm_ff});
   assign sum_tot = $signed({{2{sum_ff[SUM_W-1]}}, sum_ff}) + term_s;

   always_comb begin
      if (!acc_en_ff) begin
         sum_acc = sum_ff;
      end else if (sum_tot > SUM_MAX) begin
         sum_acc = SUM_MAX[SUM_W-1:0];
      end else if (sum_tot < SUM_MIN) begin
         sum_acc = SUM_MIN[SUM_W-1:0];
      end else begin
         sum_acc = sum_tot[SUM_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      conv_in   = conv_ff;
      i_in      = i_ff;
      n_in      = n_ff;
      acc_en_in = acc_en_ff;
      am_in     = am_ff;
      neg_in    = neg_ff;
      num_in    = num_ff;
      q0_in     = q0_ff;
      xm_in     = xm_ff;
      tm_in     = tm_ff;
      tneg_in   = tneg_ff;
      sum_in    = sum_ff;
      mul_a     = '0;
      mul_b     = '0;
      stat.busy = (state_ff != ST_IDLE);
      stat.done = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               am_in     = angle_mag;
               neg_in    = angle_neg;
               n_in      = n_terms;
               i_in      = IW'(1);
               conv_in   = 1'b1;
               acc_en_in = 1'b0;
               state_in  = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mul_a    = OPA_W'(am_ff);
            mul_b    = DEG_SCALE;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            if (conv_ff) begin
               mul_a  = prod[OPA_W-1:0];
               num_in = {prod[NUM_W-DEG_SHIFT-1:0], {DEG_SHIFT{1'b0}}};
            end else begin
               mul_a  = prod[FRAC_BITS +: OPA_W];
               num_in = NUM_W'(prod[FRAC_BITS +: OPA_W]);
            end
            mul_b    = recip_sel;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            q0_in    = prod[RECIP_SHIFT +: OPB_W];
            mul_a    = OPA_W'(prod[RECIP_SHIFT +: OPB_W]);
            mul_b    = OPB_W'(div_sel);
            state_in = ST_FIX;
         end
         ST_FIX: begin
            if (conv_ff) begin
               xm_in     = q_fix[XM_W-1:0];
               tm_in     = SUM_W'(q_fix[XM_W-1:0]);
               tneg_in   = neg_ff;
               sum_in    = x_s;
               conv_in   = 1'b0;
               acc_en_in = 1'b0;
               state_in  = (n_ff == '0) ? ST_DONE : ST_MUL1;
            end else begin
               tneg_in = ~tneg_ff;
               if (!tneg_ff) begin
                  tm_in = (q_fix > 33'h0_8000_0000) ? 32'h8000_0000 : q_fix[SUM_W-1:0];
               end else begin
                  tm_in = (q_fix > 33'h0_7fff_ffff) ? 32'h7fff_ffff : q_fix[SUM_W-1:0];
               end
               acc_en_in = 1'b1;
               if (i_ff == n_ff) begin
                  state_in = ST_DONE;
               end else begin
                  i_in     = i_ff + IW'(1);
                  state_in = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            // previous term joins the sum while the next one starts
            if (acc_en_ff) begin
               sum_in    = sum_acc;
               acc_en_in = 1'b0;
            end
            mul_a    = OPA_W'(tm_ff);
            mul_b    = OPB_W'(xm_ff);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_a    = prod[FRAC_BITS +: OPA_W];
            mul_b    = OPB_W'(xm_ff);
            state_in = ST_RECIP;
         end
         ST_DONE: begin
            sum_in    = sum_acc;
            acc_en_in = 1'b0;
            if (ctl.out_free) begin
               stat.done = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign sum = sum_acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         conv_ff   <= 1'b0;
         i_ff      <= IW'(1);
         n_ff      <= '0;
         acc_en_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         conv_ff   <= conv_in;
         i_ff      <= i_in;
         n_ff      <= n_in;
         acc_en_ff <= acc_en_in;
      end
   end

   always_ff @(posedge clock) begin
      am_ff   <= am_in;
      neg_ff  <= neg_in;
      num_ff  <= num_in;
      q0_ff   <= q0_in;
      xm_ff   <= xm_in;
      tm_ff   <= tm_in;
      tneg_ff <= tneg_in;
      sum_ff  <= sum_in;
   end

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (rem < (NUM_W'(div_sel) << 1)))
      else $error("reciprocal quotient off by more than one");

   a_term_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL1 || state_ff == ST_MUL2) |-> (i_ff != '0 && i_ff <= n_ff))
      else $error("term index out of range");

   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      stat.done |=> (state_ff == ST_IDLE && !acc_en_ff))
      else $error("sequencer did not return to idle after result");

endmodule

// ----- hw/rtl/sine_taylor_series.sv -----
// ----------------------------------------------------------------------------
// sine_taylor_series - sine of an angle by a truncated Taylor series
// Angle in 1/128 degree in, series sum in signed Q3.28 out.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_angle_degrees [15:0] signed
//   rsp      out        rsp_valid/rsp_stall rsp_sine_sum      [31:0] signed
//   csr      in         csr_wr_en           csr_wr_data       [3:0] term_count
//
// An item runs n = min(term_count, MAX_TERMS) terms after the first. Every step
// goes through the one registered multiplier: SCALE, RECIP, CHECK and FIX scale
// the angle, MUL1, MUL2, RECIP, CHECK and FIX form each term, and DONE hands
// over the sum. The next item is accepted once the sequencer is back in IDLE.
// req_stall is high while an item is in work; a result waiting on rsp_stall
// does not block the next item until that one finishes.
// Reset is synchronous and sets term_count to 5.
// ----------------------------------------------------------------------------
module sine_taylor_series #(
   parameter int MAX_TERMS = 15
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sts_pkg::ANGLE_W-1:0]  req_angle_degrees,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [sts_pkg::SUM_W-1:0]    rsp_sine_sum,
   input  logic                                csr_wr_en,
   input  logic [sts_pkg::CNT_W-1:0]           csr_wr_data
);
   import sts_pkg::*;

   localparam int IW = $clog2(MAX_TERMS+1);

   logic [CNT_W-1:0]        csr_term_count_ff, csr_term_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SUM_W-1:0] rsp_sine_sum_ff, rsp_sine_sum_in;

   sts_ctrl_type            ctl;
   sts_stat_type            stat;
   logic [MAG_W-1:0]        angle_mag;
   logic                    angle_neg;
   logic [IW-1:0]           n_terms;
   logic signed [SUM_W-1:0] core_sum;
   logic [OPA_W-1:0]        mul_a;
   logic [OPB_W-1:0]        mul_b;
   logic [PROD_W-1:0]       prod;

   assign req_stall    = stat.busy;
   assign ctl.start    = req_valid && !req_stall;
   assign ctl.out_free = !rsp_valid_ff || !rsp_stall;

   // clamp to +/-180 degrees and split into sign and magnitude
   always_comb begin
      angle_neg = (req_angle_degrees < 0);
      if (req_angle_degrees > ANGLE_LIMIT || req_angle_degrees < -ANGLE_LIMIT) begin
         angle_mag = MAG_W'(ANGLE_LIMIT);
      end else if (angle_neg) begin
         angle_mag = MAG_W'(-req_angle_degrees);
      end else begin
         angle_mag = MAG_W'(req_angle_degrees);
      end
   end

   assign n_terms = (int'(csr_term_count_ff) < MAX_TERMS) ? IW'(csr_term_count_ff)
                                                         : IW'(MAX_TERMS);

   assign csr_term_count_in = csr_wr_en ? csr_wr_data : csr_term_count_ff;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_sine_sum_in = rsp_sine_sum_ff;
      if (stat.done) begin
         rsp_valid_in    = 1'b1;
         rsp_sine_sum_in = core_sum;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_term_count_ff <= TERM_COUNT_RESET;
         rsp_valid_ff      <= 1'b0;
      end else begin
         csr_term_count_ff <= csr_term_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_sine_sum_ff <= rsp_sine_sum_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sine_sum = rsp_sine_sum_ff;

   sts_core #(
      .MAX_TERMS (MAX_TERMS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .angle_mag (angle_mag),
      .angle_neg (angle_neg),
      .n_terms   (n_terms),
      .stat      (stat),
      .sum       (core_sum),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .prod      (prod)
   );

   sts_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> req_stall)
      else $error("item accepted but block not busy");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for sine_taylor_series
// Drives angles through the request channel and checks every series sum
// against a fixed-point predictor held in the bench. A short table of corner
// angles and term counts comes first, then random phases that each set a new
// term count and idling pattern.
// ----------------------------------------------------------------------------
module testbench;
   import sts_pkg::*;

   localparam int MAX_TERMS       = 15;
   localparam int ITEMS_PER_PHASE = 200;
   localparam int N_PHASES        = 8;
   localparam int N_PROBES        = 23;

   // degrees/128 to Q3.28 radians: am * 314159 * 2^28 / (180 * 128 * 100000)
   localparam longint unsigned RAD_NUM  = 64'd314159;
   localparam longint unsigned RAD_DEN  = 64'd2304000000;
   localparam longint unsigned TERM_CAP = 64'd1 << 40;
   localparam longint          Q_MAX    = (64'sd1 <<< 31) - 1;
   localparam longint          Q_MIN    = -(64'sd1 <<< 31);

   typedef struct packed {
      logic [CNT_W-1:0]          count;
      logic signed [ANGLE_W-1:0] angle;
      logic                      known;
      logic signed [SUM_W-1:0]   sum;
   } probe_row_type;

   // known = 1 only where the sum is obvious (zero angle)
   localparam probe_row_type PROBE_ROWS [N_PROBES] = '{
      '{4'd5,  16'sd0,      1'b1, 32'sd0},
      '{4'd5,  16'sd23040,  1'b0, 32'sd0},
      '{4'd5,  -16'sd23040, 1'b0, 32'sd0},
      '{4'd5,  16'sd11520,  1'b0, 32'sd0},
      '{4'd5,  -16'sd11520, 1'b0, 32'sd0},
      '{4'd5,  16'sd1,      1'b0, 32'sd0},
      '{4'd5,  -16'sd1,     1'b0, 32'sd0},
      '{4'd5,  16'sd23041,  1'b0, 32'sd0},
      '{4'd5,  16'sd32767,  1'b0, 32'sd0},
      '{4'd5,  16'sh8000,   1'b0, 32'sd0},
      '{4'd5,  -16'sd23041, 1'b0, 32'sd0},
      '{4'd5,  16'sh5555,   1'b0, 32'sd0},
      '{4'd5,  16'shD555,   1'b0, 32'sd0},
      '{4'd0,  16'sd0,      1'b1, 32'sd0},
      '{4'd0,  16'sd23040,  1'b0, 32'sd0},
      '{4'd0,  16'sh8000,   1'b0, 32'sd0},
      '{4'd1,  16'sd11520,  1'b0, 32'sd0},
      '{4'd1,  -16'sd23040, 1'b0, 32'sd0},
      '{4'd15, 16'sd0,      1'b1, 32'sd0},
      '{4'd15, 16'sd23040,  1'b0, 32'sd0},
      '{4'd15, -16'sd23040, 1'b0, 32'sd0},
      '{4'd15, 16'sd32767,  1'b0, 32'sd0},
      '{4'd15, 16'sd7680,   1'b0, 32'sd0}
   };

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_stall;
   logic signed [ANGLE_W-1:0] req_angle_degrees = '0;
   logic                      rsp_valid;
   logic                      rsp_stall         = 1'b0;
   logic signed [SUM_W-1:0]   rsp_sine_sum;
   logic                      csr_wr_en         = 1'b0;
   logic [CNT_W-1:0]          csr_wr_data       = '0;

   logic signed [SUM_W-1:0]   sums_due [$];
   logic signed [SUM_W-1:0]   sum_want;
   logic [CNT_W-1:0]          term_count_now = TERM_COUNT_RESET;
   int                        mismatches     = 0;
   int                        idle_pct       = 0;
   int                        stall_left     = 0;

   sine_taylor_series #(
      .MAX_TERMS(MAX_TERMS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_angle_degrees(req_angle_degrees),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sine_sum     (rsp_sine_sum),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic longint clip_q328(input longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   // Taylor series sum, magnitudes truncated toward zero at every step
   function automatic logic signed [SUM_W-1:0] series_sum(
      input logic signed [ANGLE_W-1:0] angle,
      input logic [CNT_W-1:0]          count
   );
      longint          a, term, sum;
      longint unsigned am, xm, tm, m, d;
      int              n;
      bit              tneg;
      a = longint'(angle);
      if (a > longint'(ANGLE_LIMIT)) a = longint'(ANGLE_LIMIT);
      if (a < -longint'(ANGLE_LIMIT)) a = -longint'(ANGLE_LIMIT);
      am = (a < 0) ? -a : a;
      xm = am * RAD_NUM * (64'd1 << FRAC_BITS) / RAD_DEN;
      term = (a < 0) ? -longint'(xm) : longint'(xm);
      sum = term;
      n = (int'(count) < MAX_TERMS) ? int'(count) : MAX_TERMS;
      for (int i = 1; i <= n; i++) begin
         tneg = term < 0;
         tm = tneg ? -term : term;
         d = longint'(2 * i) * (2 * i + 1);
         m = (tm * xm) >> FRAC_BITS;
         m = (m * xm) >> FRAC_BITS;
         m = m / d;
         if (m > TERM_CAP) m = TERM_CAP;
         term = clip_q328(tneg ? longint'(m) : -longint'(m));
         sum = clip_q328(sum + term);
      end
      return sum[SUM_W-1:0];
   endfunction

   task automatic send_angle(input logic signed [ANGLE_W-1:0] angle,
                             input logic signed [SUM_W-1:0]   sum);
      int gap;
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_angle_degrees <= angle;
      do @(posedge clock); while (req_stall);
      sums_due.push_back(sum);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sums_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_term_count(input logic [CNT_W-1:0] count);
      drain();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      term_count_now = count;
   endtask

   // result side stalls in bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_pct != 0 && $urandom_range(0, 399) < idle_pct) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(1, 19) - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sums_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected sum %0d with nothing outstanding",
                        $realtime, rsp_sine_sum);
         end else begin
            sum_want = sums_due.pop_front();
            if (rsp_sine_sum !== sum_want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: sine_sum expected %0d, got %0d",
                           $realtime, sum_want, rsp_sine_sum);
            end
         end
      end
   end

   initial begin
      int                        r;
      logic signed [ANGLE_W-1:0] angle;
      logic [CNT_W-1:0]          count;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first rows run on the reset term count
      idle_pct = 25;
      foreach (PROBE_ROWS[k]) begin
         if (PROBE_ROWS[k].count != term_count_now)
            set_term_count(PROBE_ROWS[k].count);
         send_angle(PROBE_ROWS[k].angle,
                    PROBE_ROWS[k].known ? PROBE_ROWS[k].sum
                                        : series_sum(PROBE_ROWS[k].angle,
                                                     term_count_now));
      end

      for (int phase = 0; phase < N_PHASES; phase++) begin
         case (phase)
            0:       count = 4'd15;
            1:       count = 4'd0;
            default: count = CNT_W'($urandom_range(0, 15));
         endcase
         set_term_count(count);
         if (phase == N_PHASES - 1)
            idle_pct = 0;
         else
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 10;
               default: idle_pct = 40;
            endcase
         for (int j = 0; j < ITEMS_PER_PHASE; j++) begin
            r = $urandom_range(0, 19);
            if (r < 17) begin
               r = $urandom_range(0, 2 * ANGLE_LIMIT);
               angle = ANGLE_W'(r - ANGLE_LIMIT);
            end else if (r < 19) begin
               angle = ANGLE_W'($urandom);   // out of range angles clamp
            end else begin
               case ($urandom_range(0, 3))
                  0:       angle = ANGLE_LIMIT;
                  1:       angle = -ANGLE_LIMIT;
                  2:       angle = '0;
                  default: angle = 16'sh8000;
               endcase
            end
            send_angle(angle, series_sum(angle, term_count_now));
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (mismatches == 0 && sums_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #10ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
